[hdl/mia_pkg.sv]
// ----------------------------------------------------------------------------
// mia_pkg
// Shared constants, command codes and status types of the matrix inverse block.
// ----------------------------------------------------------------------------
package mia_pkg;

    localparam int MAX_DIM       = 8;
    localparam int FRACTION_BITS = 16;
    localparam int ELEM_W        = 32;
    localparam int ACC_W         = 64;
    localparam int DIM_W         = $clog2(MAX_DIM);
    localparam int SIZE_W        = $clog2(MAX_DIM + 1);
    localparam int ADDR_W        = 2 * DIM_W;
    localparam int DEPTH         = MAX_DIM * MAX_DIM;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int DIV_STEPS     = ACC_W + FRACTION_BITS;
    localparam int DCNT_W        = $clog2(DIV_STEPS);
    localparam int Q_W           = ELEM_W + 2;
    localparam int CFG_W         = 4;
    localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(4);

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DET_START,
        OP_ADJ_START,
        OP_ENTER,
        OP_DESCEND,
        OP_LEAF,
        OP_RETURN,
        OP_READ,
        OP_MAG,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_SCALE,
        OP_ACC,
        OP_STEP,
        OP_FINISH,
        OP_DET_SAVE,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_EMIT,
        OP_EMIT_SING
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic load_last;
        logic leaf;
        logic top;
        logic has_next;
        logic det_zero;
        logic div_last;
        logic rc_last;
        logic out_free;
    } dp_status_t;

endpackage

[hdl/matrix_inverse_by_adjugate.sv]
// ----------------------------------------------------------------------------
// matrix_inverse_by_adjugate
// Inverts an n-by-n signed Q16.16 matrix through its adjugate.
// ----------------------------------------------------------------------------
// Usage:
//   Write the size n (1..8; 0 acts as 1, above 8 as 8) on cfg_wen/cfg_wdata
//   while the block is idle; a write drops any partly loaded matrix.
//   Stream n*n elements row-major on the s_ channel, one transaction a cycle.
//   After the last element s_tready stays low while the determinant is
//   expanded along the first row by a recursive sequencer over a stack of
//   frames, one term at a time through a shared 32x32 multiplier, and then
//   each adjugate entry is expanded the same way. Each element then goes
//   through a bit-serial divider before it is presented.
//   A zero determinant gives one transaction with the singular flag and
//   tlast set; otherwise n*n transactions follow row-major, tlast on the
//   last. A stalled m_ side holds the output register and pauses the work.
//   Reset (aresetn low, synchronous) sets n to 4 and clears the load count.
// ----------------------------------------------------------------------------
module matrix_inverse_by_adjugate import mia_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wen,
    input  logic [CFG_W-1:0] cfg_wdata,   // matrix_size
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,     // [31:0] element_value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,     // [31:0] inverse_value, [34:32] row_index,
                                          // [37:35] column_index, [39:38] zero
    output logic [1:0]       m_tuser,     // [0] singular_flag, [1] saturated_flag
    output logic             m_tlast      // last_result
);

    dp_cmd_t                  cmd;
    dp_status_t               st;
    logic signed [ELEM_W-1:0] out_value;
    logic [DIM_W-1:0]         out_row, out_col;
    logic                     out_singular, out_saturated;

    // sequence the load, expansion and division steps
    mia_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // hold the matrix, stack, arithmetic and output register
    mia_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .elem_in       (s_tdata),
        .cmd           (cmd),
        .st            (st),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_value     (out_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .out_singular  (out_singular),
        .out_saturated (out_saturated),
        .out_last      (m_tlast)
    );

    // pack the result fields from the lowest bit up
    assign m_tdata = {2'b00, out_col, out_row, out_value};
    assign m_tuser = {out_saturated, out_singular};

endmodule

[hdl/mia_ram.sv]
// ----------------------------------------------------------------------------
// mia_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hdl/mia_ctrl.sv]
// ----------------------------------------------------------------------------
// mia_ctrl
// Sequencer: load, recursive cofactor expansion, division and emission.
// ----------------------------------------------------------------------------
module mia_ctrl import mia_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_LOAD, S_DET, S_ENTER, S_ITER, S_RET, S_READ, S_MAG, S_MUL_LO,
        S_MUL_HI, S_SCALE, S_ACC, S_NEXT, S_DONE, S_SING, S_ADJ, S_DIV
    } state_t;

    typedef enum logic [0:0] { PH_DET, PH_ADJ } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   emit_wait;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        emit_wait  = 1'b0;
        case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = OP_LOAD;
                    if (st.load_last) state_next = S_DET;
                end
            end
            S_DET: begin
                cmd.op     = OP_DET_START;
                phase_next = PH_DET;
                state_next = S_ENTER;
            end
            S_ENTER: begin
                if (st.leaf) begin
                    cmd.op     = OP_LEAF;
                    state_next = S_RET;
                end else begin
                    cmd.op     = OP_ENTER;
                    state_next = S_ITER;
                end
            end
            S_ITER: begin
                cmd.op     = OP_DESCEND;
                state_next = S_ENTER;
            end
            S_RET: begin
                if (st.top) begin
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_RETURN;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.op     = OP_READ;
                state_next = S_MAG;
            end
            S_MAG: begin
                cmd.op     = OP_MAG;
                state_next = S_MUL_LO;
            end
            S_MUL_LO: begin
                cmd.op     = OP_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.op     = OP_MUL_HI;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.op     = OP_SCALE;
                state_next = S_ACC;
            end
            S_ACC: begin
                cmd.op     = OP_ACC;
                state_next = S_NEXT;
            end
            S_NEXT: begin
                if (st.has_next) begin
                    cmd.op     = OP_STEP;
                    state_next = S_ITER;
                end else begin
                    cmd.op     = OP_FINISH;
                    state_next = S_RET;
                end
            end
            S_DONE: begin
                if (phase_reg == PH_ADJ) begin
                    cmd.op     = OP_DIV_START;
                    state_next = S_DIV;
                end else if (st.det_zero) begin
                    state_next = S_SING;
                end else begin
                    cmd.op     = OP_DET_SAVE;
                    state_next = S_ADJ;
                end
            end
            S_SING: begin
                if (st.out_free) begin
                    cmd.op     = OP_EMIT_SING;
                    state_next = S_LOAD;
                end
            end
            S_ADJ: begin
                cmd.op     = OP_ADJ_START;
                phase_next = PH_ADJ;
                state_next = S_ENTER;
            end
            S_DIV: begin
                emit_wait = st.div_last;
                if (!st.div_last) begin
                    cmd.op = OP_DIV_STEP;
                end else if (st.out_free) begin
                    cmd.op     = OP_EMIT;
                    state_next = st.rc_last ? S_LOAD : S_ADJ;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // emit_wait marks the cycles spent holding a finished quotient
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            phase_reg <= PH_DET;
        end else begin
            state_reg <= state_next;
            phase_reg <= (emit_wait && state_next == S_LOAD) ? PH_DET : phase_next;
        end
    end

endmodule

[hdl/mia_dpath.sv]
// ----------------------------------------------------------------------------
// mia_dpath
// Element store, expansion stack, shared multiplier, divider and output register.
// ----------------------------------------------------------------------------
module mia_dpath import mia_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wen,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic [ELEM_W-1:0]        elem_in,
    input  dp_cmd_t                  cmd,
    output dp_status_t               st,
    input  logic                     out_ready,
    output logic                     out_valid,
    output logic signed [ELEM_W-1:0] out_value,
    output logic [DIM_W-1:0]         out_row,
    output logic [DIM_W-1:0]         out_col,
    output logic                     out_singular,
    output logic                     out_saturated,
    output logic                     out_last
);

    localparam logic [ACC_W-1:0] ONE     = ACC_W'(1) << FRACTION_BITS;
    localparam logic [ACC_W-1:0] MAX64   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] MIN64   = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [Q_W-1:0]   QCAP    = Q_W'(1) << (ELEM_W + 1);
    localparam logic [Q_W-1:0]   LIM_NEG = Q_W'(1) << (ELEM_W - 1);
    localparam logic [Q_W-1:0]   LIM_POS = (Q_W'(1) << (ELEM_W - 1)) - Q_W'(1);
    localparam int               PROD_W  = ACC_W + ELEM_W;

    // control registers
    logic [CFG_W-1:0]  size_reg;
    logic [CNT_W-1:0]  load_cnt_reg;
    logic              out_valid_reg;
    logic [ACC_W-1:0]  det_reg;

    // recursion stack and working registers
    logic [MAX_DIM-1:0] mask_reg [0:MAX_DIM];
    logic [ACC_W-1:0]   acc_reg  [0:MAX_DIM-1];
    logic               par_reg  [0:MAX_DIM-1];
    logic [DIM_W-1:0]   col_reg  [0:MAX_DIM-1];
    logic [SIZE_W-1:0]  lvl_reg, k0_reg, skip_reg;
    logic [DIM_W-1:0]   r_reg, c_reg;
    logic [ACC_W-1:0]   ret_reg, mb_reg, p0_reg, p1_reg, term_reg;
    logic [ELEM_W-1:0]  ma_reg;
    logic               neg_reg;

    // divider
    logic [DIV_STEPS-1:0] dvd_reg;
    logic [ACC_W-1:0]     rem_reg, md_reg;
    logic [Q_W-1:0]       q_reg;
    logic [DCNT_W-1:0]    dcnt_reg;
    logic                 dneg_reg;

    // output payload
    logic [ELEM_W-1:0] ovalue_reg;
    logic [DIM_W-1:0]  orow_reg, ocol_reg;
    logic              osing_reg, osat_reg, olast_reg;

    logic [SIZE_W-1:0]   n_eff;
    logic [2*SIZE_W-1:0] total;
    logic [DIM_W-1:0]    lvl_idx, cur_col, next_col, first_col;
    logic [MAX_DIM-1:0]  cur_mask, above, all_mask;
    logic [MAX_DIM:0]    thru, all_ext;
    logic [ACC_W-1:0]    cur_acc;
    logic                cur_par;
    logic [SIZE_W-1:0]   row_w;
    logic [2*SIZE_W-1:0] addr_full;
    logic [ELEM_W-1:0]   rdata;
    logic [PROD_W-1:0]   prod, prod_r, shifted;
    logic [ACC_W:0]      sum;
    logic [ACC_W-1:0]    term_val, acc_val, adj_s, adj_mag, det_mag;
    logic [ACC_W:0]      rem_sh, rem_dif;
    logic                qb;
    logic [Q_W:0]        q_sh;
    logic [Q_W-1:0]      q_val, q_lim;
    logic                div_sat;
    logic [ELEM_W-1:0]   div_val;
    logic                rc_last;

    function automatic logic [DIM_W-1:0] first_set(input logic [MAX_DIM-1:0] m);
        logic [DIM_W-1:0] idx;
        idx = '0;
        for (int i = MAX_DIM - 1; i >= 0; i--) begin
            if (m[i]) idx = DIM_W'(i);
        end
        return idx;
    endfunction

    always_comb begin
        if (size_reg == '0) begin
            n_eff = SIZE_W'(1);
        end else if (size_reg > CFG_W'(MAX_DIM)) begin
            n_eff = SIZE_W'(MAX_DIM);
        end else begin
            n_eff = SIZE_W'(size_reg);
        end
    end

    assign total     = (2*SIZE_W)'(n_eff) * (2*SIZE_W)'(n_eff);
    assign lvl_idx   = lvl_reg[DIM_W-1:0];
    assign cur_mask  = mask_reg[lvl_reg];
    assign cur_col   = col_reg[lvl_idx];
    assign cur_acc   = acc_reg[lvl_idx];
    assign cur_par   = par_reg[lvl_idx];
    assign thru      = ((MAX_DIM+1)'(2) << cur_col) - (MAX_DIM+1)'(1);
    assign above     = cur_mask & ~thru[MAX_DIM-1:0];
    assign next_col  = first_set(above);
    assign first_col = first_set(cur_mask);
    assign all_ext   = ((MAX_DIM+1)'(1) << n_eff) - (MAX_DIM+1)'(1);
    assign all_mask  = all_ext[MAX_DIM-1:0];

    // row of the current level: skip the adjugate's removed row
    assign row_w     = lvl_reg + ((lvl_reg >= skip_reg) ? SIZE_W'(1) : SIZE_W'(0));
    assign addr_full = (2*SIZE_W)'(row_w) * (2*SIZE_W)'(n_eff) + (2*SIZE_W)'(cur_col);

    mia_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (cmd.op == OP_LOAD),
        .waddr (load_cnt_reg[ADDR_W-1:0]),
        .wdata (elem_in),
        .raddr (addr_full[ADDR_W-1:0]),
        .rdata (rdata)
    );

    // scale the 96-bit product down, rounding toward minus infinity
    always_comb begin
        prod_r   = {{ELEM_W{1'b0}}, p0_reg} + {p1_reg, {ELEM_W{1'b0}}};
        prod     = neg_reg ? prod_r + PROD_W'((ACC_W'(1) << FRACTION_BITS) - 1) : prod_r;
        shifted  = prod >> FRACTION_BITS;
        if (shifted[PROD_W-1:ACC_W-1] != '0) begin
            term_val = neg_reg ? MIN64 : MAX64;
        end else begin
            term_val = neg_reg ? (~shifted[ACC_W-1:0] + ACC_W'(1)) : shifted[ACC_W-1:0];
        end
    end

    always_comb begin
        sum = {cur_acc[ACC_W-1], cur_acc} + {term_reg[ACC_W-1], term_reg};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            acc_val = sum[ACC_W] ? MIN64 : MAX64;
        end else begin
            acc_val = sum[ACC_W-1:0];
        end
    end

    // sign the cofactor and take magnitudes for the divider
    always_comb begin
        if (r_reg[0] ^ c_reg[0]) begin
            adj_s = (ret_reg == MIN64) ? MAX64 : (~ret_reg + ACC_W'(1));
        end else begin
            adj_s = ret_reg;
        end
        adj_mag = adj_s[ACC_W-1] ? (~adj_s + ACC_W'(1)) : adj_s;
        det_mag = det_reg[ACC_W-1] ? (~det_reg + ACC_W'(1)) : det_reg;
    end

    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[DIV_STEPS-1]};
        rem_dif = rem_sh - {1'b0, md_reg};
        qb      = rem_sh >= {1'b0, md_reg};
        q_sh    = {q_reg, qb};
        q_val   = (q_sh > {1'b0, QCAP}) ? QCAP : q_sh[Q_W-1:0];
        q_lim   = dneg_reg ? LIM_NEG : LIM_POS;
        div_sat = q_reg > q_lim;
        if (div_sat) begin
            div_val = dneg_reg ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
        end else begin
            div_val = dneg_reg ? (~q_reg[ELEM_W-1:0] + ELEM_W'(1)) : q_reg[ELEM_W-1:0];
        end
    end

    assign rc_last = ({1'b0, r_reg} == n_eff - SIZE_W'(1)) &&
                     ({1'b0, c_reg} == n_eff - SIZE_W'(1));

    always_comb begin
        st.load_last = ((2*SIZE_W)'(load_cnt_reg) + (2*SIZE_W)'(1)) == total;
        st.leaf      = lvl_reg == k0_reg;
        st.top       = lvl_reg == '0;
        st.has_next  = above != '0;
        st.det_zero  = ret_reg == '0;
        st.div_last  = dcnt_reg == DCNT_W'(DIV_STEPS);
        st.rc_last   = rc_last;
        st.out_free  = !out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= SIZE_RESET;
            load_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            det_reg       <= '0;
        end else begin
            if (cfg_wen) begin
                size_reg     <= cfg_wdata;
                load_cnt_reg <= '0;
            end else if (cmd.op == OP_LOAD) begin
                load_cnt_reg <= st.load_last ? '0 : load_cnt_reg + CNT_W'(1);
            end
            if (cmd.op == OP_DET_SAVE) det_reg <= ret_reg;
            if (cmd.op == OP_EMIT || cmd.op == OP_EMIT_SING) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_DET_START: begin
                k0_reg      <= n_eff;
                skip_reg    <= SIZE_W'(MAX_DIM);
                mask_reg[0] <= all_mask;
                lvl_reg     <= '0;
                r_reg       <= '0;
                c_reg       <= '0;
            end
            OP_ADJ_START: begin
                k0_reg      <= n_eff - SIZE_W'(1);
                skip_reg    <= {1'b0, c_reg};
                mask_reg[0] <= all_mask & ~(MAX_DIM'(1) << r_reg);
                lvl_reg     <= '0;
            end
            OP_ENTER: begin
                acc_reg[lvl_idx] <= '0;
                par_reg[lvl_idx] <= 1'b0;
                col_reg[lvl_idx] <= first_col;
            end
            OP_DESCEND: begin
                mask_reg[lvl_reg + SIZE_W'(1)] <= cur_mask & ~(MAX_DIM'(1) << cur_col);
                lvl_reg <= lvl_reg + SIZE_W'(1);
            end
            OP_LEAF:   ret_reg <= ONE;
            OP_RETURN: lvl_reg <= lvl_reg - SIZE_W'(1);
            OP_READ:   mb_reg  <= ret_reg[ACC_W-1] ? (~ret_reg + ACC_W'(1)) : ret_reg;
            OP_MAG: begin
                ma_reg  <= rdata[ELEM_W-1] ? (~rdata + ELEM_W'(1)) : rdata;
                neg_reg <= rdata[ELEM_W-1] ^ ret_reg[ACC_W-1] ^ cur_par;
            end
            OP_MUL_LO: p0_reg <= ACC_W'(ma_reg) * ACC_W'(mb_reg[ELEM_W-1:0]);
            OP_MUL_HI: p1_reg <= ACC_W'(ma_reg) * ACC_W'(mb_reg[ACC_W-1:ELEM_W]);
            OP_SCALE:  term_reg <= term_val;
            OP_ACC:    acc_reg[lvl_idx] <= acc_val;
            OP_STEP: begin
                col_reg[lvl_idx] <= next_col;
                par_reg[lvl_idx] <= ~cur_par;
            end
            OP_FINISH: ret_reg <= cur_acc;
            OP_DIV_START: begin
                dneg_reg <= adj_s[ACC_W-1] ^ det_reg[ACC_W-1];
                md_reg   <= det_mag;
                dvd_reg  <= {adj_mag, {FRACTION_BITS{1'b0}}};
                rem_reg  <= '0;
                q_reg    <= '0;
                dcnt_reg <= '0;
            end
            OP_DIV_STEP: begin
                dvd_reg  <= dvd_reg << 1;
                rem_reg  <= qb ? rem_dif[ACC_W-1:0] : rem_sh[ACC_W-1:0];
                q_reg    <= q_val;
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            OP_EMIT: begin
                ovalue_reg <= div_val;
                orow_reg   <= r_reg;
                ocol_reg   <= c_reg;
                osing_reg  <= 1'b0;
                osat_reg   <= div_sat;
                olast_reg  <= rc_last;
                if ({1'b0, c_reg} == n_eff - SIZE_W'(1)) begin
                    c_reg <= '0;
                    r_reg <= r_reg + DIM_W'(1);
                end else begin
                    c_reg <= c_reg + DIM_W'(1);
                end
            end
            OP_EMIT_SING: begin
                ovalue_reg <= '0;
                orow_reg   <= '0;
                ocol_reg   <= '0;
                osing_reg  <= 1'b1;
                osat_reg   <= 1'b0;
                olast_reg  <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign out_value     = ovalue_reg;
    assign out_row       = orow_reg;
    assign out_col       = ocol_reg;
    assign out_singular  = osing_reg;
    assign out_saturated = osat_reg;
    assign out_last      = olast_reg;

endmodule

[dv/mia_checker.sv]
// ----------------------------------------------------------------------------
// mia_checker
// Watches the element and result streams of the matrix inverse block, keeps
// its own copy of the loaded matrix and size, predicts the inverse (or the
// singular marker) of each completed matrix and compares every result.
// ----------------------------------------------------------------------------
module mia_checker import mia_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wen,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [31:0]      s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [39:0]      m_tdata,
    input  logic [1:0]       m_tuser,
    input  logic             m_tlast,
    output int               pending,
    output int               errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint I64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [31:0] value;
        logic [2:0]  row;
        logic [2:0]  col;
        logic        singular;
        logic        saturated;
        logic        last;
    } inv_elem_t;

    inv_elem_t   inverse_q[$];
    logic [31:0] elem_mem[DEPTH];
    logic [3:0]  size_reg;
    int          load_cnt;
    int          dim;

    function automatic longint elem_at(int r, int c);
        return longint'($signed(elem_mem[(r * dim + c) % DEPTH]));
    endfunction

    function automatic longint sat_add(longint a, longint b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? I64_MIN : I64_MAX;
        return s[63:0];
    endfunction

    // (a * b) / 2^F rounded toward minus infinity, sign flip applied first
    function automatic longint scaled_product(longint a, longint b, bit flip);
        bit           neg;
        logic [63:0]  ma, mb;
        logic [127:0] p;
        neg = ((a < 0) != (b < 0)) != flip;
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = {64'b0, ma} * {64'b0, mb};
        if (neg) p = p + ((128'd1 << FRACTION_BITS) - 1);
        p = p >> FRACTION_BITS;
        if (neg) return (p >= 128'h8000_0000_0000_0000) ? I64_MIN : -longint'(p[63:0]);
        return (p > 128'h7FFF_FFFF_FFFF_FFFF) ? I64_MAX : longint'(p[63:0]);
    endfunction

    // Laplace expansion along the first listed row
    function automatic longint minor_det(int k, int rows[MAX_DIM], int roff,
                                         int cols[MAX_DIM]);
        int     sub[MAX_DIM];
        longint acc;
        int     m;
        acc = 0;
        if (k == 0) return longint'(1) << FRACTION_BITS;
        for (int i = 0; i < k; i++) begin
            m = 0;
            for (int j = 0; j < k; j++) begin
                if (j != i) begin
                    sub[m] = cols[j];
                    m++;
                end
            end
            acc = sat_add(acc, scaled_product(elem_at(rows[roff], cols[i]),
                          minor_det(k - 1, rows, roff + 1, sub), i % 2 == 1));
        end
        return acc;
    endfunction

    // (num * 2^F) / den truncated toward zero, clipped to 32 bits
    function automatic logic [31:0] quotient_q16(longint num, longint den,
                                                 output logic sat);
        bit           neg;
        logic [63:0]  mn, md;
        logic [127:0] q;
        neg = (num < 0) != (den < 0);
        mn  = (num < 0) ? -num : num;
        md  = (den < 0) ? -den : den;
        q   = ({64'b0, mn} << FRACTION_BITS) / {64'b0, md};
        sat = q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF);
        if (sat) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return neg ? -q[31:0] : q[31:0];
    endfunction

    task automatic predict_inverse();
        int        rows[MAX_DIM], cols[MAX_DIM];
        longint    det, adj;
        inv_elem_t e;
        int        m;
        for (int i = 0; i < MAX_DIM; i++) begin
            rows[i] = i;
            cols[i] = i;
        end
        det = minor_det(dim, rows, 0, cols);
        if (det == 0) begin
            e = '{value: '0, row: '0, col: '0, singular: 1'b1, saturated: 1'b0, last: 1'b1};
            inverse_q.push_back(e);
            return;
        end
        for (int r = 0; r < dim; r++) begin
            for (int c = 0; c < dim; c++) begin
                m = 0;
                for (int i = 0; i < dim; i++) if (i != c) begin rows[m] = i; m++; end
                m = 0;
                for (int i = 0; i < dim; i++) if (i != r) begin cols[m] = i; m++; end
                adj = minor_det(dim - 1, rows, 0, cols);
                if ((r + c) % 2 == 1) adj = (adj == I64_MIN) ? I64_MAX : -adj;
                e.value    = quotient_q16(adj, det, e.saturated);
                e.row      = 3'(r);
                e.col      = 3'(c);
                e.singular = 1'b0;
                e.last     = (r * dim + c + 1 == dim * dim);
                inverse_q.push_back(e);
            end
        end
    endtask

    always @(posedge aclk) begin
        inv_elem_t e;
        if (!aresetn) begin
            size_reg = SIZE_RESET;
            load_cnt = 0;
            inverse_q.delete();
            errors = 0;
        end else begin
            if (cfg_wen) begin
                size_reg = cfg_wdata;
                load_cnt = 0;
            end
            if (s_tvalid && s_tready) begin
                dim = (size_reg < 1) ? 1 : (size_reg > MAX_DIM) ? MAX_DIM : size_reg;
                elem_mem[load_cnt % DEPTH] = s_tdata;
                load_cnt++;
                if (load_cnt >= dim * dim) begin
                    load_cnt = 0;
                    predict_inverse();
                end
            end
            if (m_tvalid && m_tready) begin
                if (inverse_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result: data %h user %b last %b",
                                               m_tdata, m_tuser, m_tlast);
                end else begin
                    e = inverse_q.pop_front();
                    if (m_tdata[31:0] !== e.value || m_tdata[34:32] !== e.row ||
                        m_tdata[37:35] !== e.col || m_tuser[0] !== e.singular ||
                        m_tuser[1] !== e.saturated || m_tlast !== e.last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp val %h r%0d c%0d sing %b sat %b last %b",
                                      " / got val %h r%0d c%0d sing %b sat %b last %b"},
                                     e.value, e.row, e.col, e.singular, e.saturated, e.last,
                                     m_tdata[31:0], m_tdata[34:32], m_tdata[37:35],
                                     m_tuser[0], m_tuser[1], m_tlast);
                    end
                end
            end
        end
        pending = inverse_q.size();
    end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the matrix inverse block: directed corner matrices
// of sizes 1, 2, 3 and 8, then random well-formed matrices of small sizes with
// random stalls on both streams. Checking is done by mia_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import mia_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous ceiling on the run, which includes an 8x8 determinant expansion.
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wen = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [39:0]      m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;

    int pending, errors;
    int cycles = 0;
    int elems_sent = 0;
    bit calm = 1'b0;        // no random idling on either side while set
    bit hold_req = 1'b0;    // ask the receiver for one long stall

    always #2 aclk = ~aclk;

    matrix_inverse_by_adjugate u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    mia_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast), .pending(pending), .errors(errors)
    );

    // Watchdog: abort a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random backpressure, plus one long hold-off on request so the
    // block fills up and stops taking elements.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 24);
            end
        end
    end

    // Push one element; a transaction completes at the edge where s_tready
    // is seen high with s_tvalid up.
    task automatic push_elem(logic [31:0] v);
        if (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        elems_sent++;
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_size(logic [CFG_W-1:0] n);
        drain();
        cfg_wen   <= 1'b1;
        cfg_wdata <= n;
        @(posedge aclk);
        cfg_wen   <= 1'b0;
    endtask

    // Random element: mostly moderate Q16.16 values, sometimes any 32 bits.
    function automatic logic [31:0] rand_elem();
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return 32'($signed($urandom_range(16)) - 8) <<< 16;
            3:       return $urandom_range(3);
            default: return 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
        endcase
    endfunction

    // One n-by-n matrix; occasionally copy row 0 into row 1 to force singular.
    task automatic push_matrix(int n);
        logic [31:0] row0[MAX_DIM];
        bit          dup;
        logic [31:0] v;
        dup = (n > 1) && ($urandom_range(9) == 0);
        for (int k = 0; k < n * n; k++) begin
            v = rand_elem();
            if (k < n) row0[k] = v;
            if (dup && k >= n && k < 2 * n) v = row0[k - n];
            push_elem(v);
        end
    endtask

    initial begin
        int n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: 1x1 corners (one, zero, extremes, tiny value that saturates).
        write_size(4'd1);
        push_elem(Q_ONE);
        push_elem(32'h0000_0000);
        push_elem(32'h8000_0000);
        push_elem(32'h7FFF_FFFF);
        push_elem(32'h0000_0001);
        push_elem(32'hFFFF_FFFF);
        // Size zero behaves as one.
        write_size(4'd0);
        push_elem(32'hFFFE_0000);
        // 2x2 identity, then a singular pair of equal rows.
        write_size(4'd2);
        push_elem(Q_ONE); push_elem(32'h0); push_elem(32'h0); push_elem(Q_ONE);
        push_elem(Q_ONE); push_elem(Q_ONE); push_elem(Q_ONE); push_elem(Q_ONE);
        // A partly loaded matrix is dropped by a size write.
        push_elem(32'h1234_5678); push_elem(32'h8765_4321);
        write_size(4'd8);
        push_elem(Q_ONE); push_elem(32'h0003_0000);
        // Size above the maximum acts as 8; an all-zero matrix is singular.
        write_size(4'd15);
        for (int k = 0; k < 64; k++) push_elem(32'h0);
        write_size(4'd3);
        push_matrix(3);

        // Pressure: back-to-back 2x2 matrices while the receiver stalls long.
        write_size(4'd2);
        calm = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 6; k++) push_matrix(2);
        drain();
        calm = 1'b0;

        // Random phases over small sizes, with a calm stretch in the middle.
        while (elems_sent < 290) begin
            n = ($urandom_range(19) == 0) ? 5 : $urandom_range(1, 4);
            write_size(4'(n));
            calm = (elems_sent > 200 && elems_sent < 250);
            repeat ($urandom_range(1, 4)) push_matrix(n);
            if ($urandom_range(5) == 0) begin
                // a broken run: extra elements, a partial matrix thrown away by the next write
                repeat ($urandom_range(1, n * n)) push_elem(rand_elem());
                if ($urandom_range(1) == 0 && n * n > 1) begin
                    write_size(4'(n));
                end
            end
        end
        calm = 1'b0;

        // Drop leftovers of any partial load, then let the pipeline settle.
        write_size(4'd1);
        drain();
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
